FILE: src/ngh_pkg.sv
// ----------------------------------------------------------------------------
// ngh_pkg: shared types and constants
// Payload structs, item kinds, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package ngh_pkg;

  localparam int NGRAM_MAX  = 3;
  localparam int HEADS_MAX  = 8;
  localparam int TOKEN_BITS = 32;

  localparam int PREV_DEPTH = NGRAM_MAX - 1;
  localparam int HEAD_DEPTH = (NGRAM_MAX - 1) * HEADS_MAX;
  localparam int HEAD_IW    = 4;
  localparam int SHIFT_W    = $clog2(NGRAM_MAX);
  localparam int ORD_W      = (NGRAM_MAX > 2) ? $clog2(NGRAM_MAX - 1) : 1;
  localparam int SEG_W      = $clog2(NGRAM_MAX);
  localparam int HCNT_W     = $clog2(HEADS_MAX + 1);
  localparam int TOTAL_W    = $clog2(HEAD_DEPTH + 1);
  localparam int MUL_IW     = (NGRAM_MAX > 1) ? $clog2(NGRAM_MAX) : 1;

  typedef enum logic [2:0] {
    KIND_TOKEN = 3'd0,
    KIND_MUL   = 3'd1,
    KIND_MOD   = 3'd2,
    KIND_OFF   = 3'd3,
    KIND_START = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CFG_EOS   = 2'd0,
    CFG_ORDER = 2'd1,
    CFG_HEADS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] token;
    logic [3:0]  table_index;
    logic [62:0] table_value;
  } in_t;

  typedef struct packed {
    logic [3:0]  head;
    logic [40:0] ngram_id;
    logic        last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic               tok_load;
    logic               mul_en;
    logic [SHIFT_W-1:0] shift;
    logic [1:0]         phase;
    logic               hist_upd;
    logic               div_init;
    logic               div_step;
    logic               fin;
    logic [3:0]         head;
    logic [ORD_W-1:0]   ord;
    logic               last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [HCNT_W-1:0]  heads;
    logic [TOTAL_W-1:0] total;
  } sts_t;

endpackage

FILE: src/ngh_ctrl.sv
// ----------------------------------------------------------------------------
// ngh_ctrl: sequencer
// Steps the product phases, the bit-serial remainder and the head loop.
// ----------------------------------------------------------------------------
module ngh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [2:0]    in_kind_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ngh_pkg::sts_t sts_i,
  output ngh_pkg::cmd_t cmd_o
);
  import ngh_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [1:0]         phase_q, phase_d;
  logic [5:0]         bit_q, bit_d;
  logic [3:0]         h_q, h_d;
  logic [HCNT_W-1:0]  j_q, j_d;
  logic [ORD_W-1:0]   ord_q, ord_d;
  logic               ov_q, ov_d;
  logic               last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign last = ({{(TOTAL_W-4){1'b0}}, h_q} + TOTAL_W'(1)) == sts_i.total;

  // next state and commands
  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    h_d     = h_q;
    j_d     = j_q;
    ord_d   = ord_q;
    ov_d    = ov_q;
    cmd_o          = '0;
    cmd_o.shift    = shift_q;
    cmd_o.phase    = phase_q;
    cmd_o.head     = h_q;
    cmd_o.ord      = ord_q;
    cmd_o.last     = last;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_kind_i == KIND_TOKEN) begin
          cmd_o.tok_load = 1'b1;
          shift_d = '0;
          phase_d = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (phase_q == 2'd2) begin
          phase_d = '0;
          if (shift_q == SHIFT_W'(NGRAM_MAX - 1)) begin
            cmd_o.hist_upd = 1'b1;
            h_d   = '0;
            j_d   = '0;
            ord_d = '0;
            state_d = (sts_i.total == '0) ? S_IDLE : S_LOAD;
          end else begin
            shift_d = shift_q + SHIFT_W'(1);
          end
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end
      S_LOAD: begin
        cmd_o.div_init = 1'b1;
        bit_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        bit_d = bit_q + 6'd1;
        if (bit_q == 6'd63) state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.fin = 1'b1;
        ov_d    = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (last) begin
            state_d = S_IDLE;
          end else begin
            h_d = h_q + 4'd1;
            if (j_q + HCNT_W'(1) == sts_i.heads) begin
              j_d   = '0;
              ord_d = ord_q + ORD_W'(1);
            end else begin
              j_d = j_q + HCNT_W'(1);
            end
            state_d = S_LOAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      shift_q <= '0;
      phase_q <= '0;
      bit_q   <= '0;
      h_q     <= '0;
      j_q     <= '0;
      ord_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      shift_q <= shift_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      h_q     <= h_d;
      j_q     <= j_d;
      ord_q   <= ord_d;
      ov_q    <= ov_d;
    end
  end

  // a held result blocks new items
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");

  // final result taken returns to idle
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_ready_i && last) |=> state_q == S_IDLE)
    else $error("no return to idle");

  // remainder runs its full bit count
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && bit_q != 6'd63) |=> state_q == S_DIV)
    else $error("remainder cut short");

endmodule

FILE: src/ngh_dp.sv
// ----------------------------------------------------------------------------
// ngh_dp: datapath
// Configuration, tables, token history, shared multiplier, serial remainder, result register.
// ----------------------------------------------------------------------------
module ngh_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_acc_i,
  input  ngh_pkg::in_t  in_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  ngh_pkg::cmd_t cmd_i,
  output ngh_pkg::sts_t sts_o,
  output ngh_pkg::out_t out_o
);
  import ngh_pkg::*;

  logic [31:0] eos_q;
  logic [1:0]  ord_cfg_q;
  logic [3:0]  heads_cfg_q;

  logic [TOKEN_BITS-1:0] tok_q;
  logic [TOKEN_BITS-1:0] prev_q [PREV_DEPTH];
  logic [SEG_W-1:0]      seg_q;

  logic [62:0] mult_q [NGRAM_MAX];
  logic [31:0] mod_q  [HEAD_DEPTH];
  logic [40:0] off_q  [HEAD_DEPTH];

  logic [63:0] mul_q, part_q, acc_q;
  logic [63:0] mix_q [PREV_DEPTH];
  logic [63:0] dvd_q;
  logic [31:0] rem_q, p_q;
  logic        neg_q;
  out_t        out_q;

  logic [TOKEN_BITS-1:0] eos_t;
  logic [TOKEN_BITS-1:0] shifted [NGRAM_MAX];
  logic [31:0]           op_a, op_lo, op_hi;
  logic [63:0]           prod, psum, acc_d, mval, mag;
  logic [SHIFT_W-1:0]    sm1;
  logic [32:0]           r2;
  logic                  ge;
  logic [31:0]           res;
  logic [3:0]            ord_eff;
  logic [HCNT_W-1:0]     heads_eff;
  logic [7:0]            total_w;

  assign eos_t = eos_q[TOKEN_BITS-1:0];

  // effective order and head count
  always_comb begin
    ord_eff = {2'b00, ord_cfg_q};
    if (ord_eff < 4'd2) ord_eff = 4'd2;
    if (ord_eff > 4'(NGRAM_MAX)) ord_eff = 4'(NGRAM_MAX);
    if ({1'b0, heads_cfg_q} > 5'(HEADS_MAX)) heads_eff = HCNT_W'(HEADS_MAX);
    else heads_eff = HCNT_W'(heads_cfg_q);
    total_w = 8'(ord_eff - 4'd1) * 8'(heads_eff);
  end
  assign sts_o.heads = heads_eff;
  assign sts_o.total = total_w[TOTAL_W-1:0];

  // shifted tokens, padded before the segment start
  always_comb begin
    shifted[0] = tok_q;
    for (int s = 1; s < NGRAM_MAX; s++) begin
      shifted[s] = ({1'b0, seg_q} >= (SEG_W+1)'(s)) ? prev_q[s-1] : eos_t;
    end
  end

  // 32x32 multiplies: low half of the multiplier in phase 0, then high half in phase 1
  assign op_a  = 32'(shifted[cmd_i.shift]);
  assign op_lo = mult_q[cmd_i.shift][31:0];
  assign op_hi = {1'b0, mult_q[cmd_i.shift][62:32]};
  assign prod  = op_a * ((cmd_i.phase == 2'd0) ? op_lo : op_hi);
  assign psum  = part_q + {mul_q[31:0], 32'h0};
  assign acc_d = (cmd_i.shift == '0) ? psum : (acc_q ^ psum);
  assign sm1   = cmd_i.shift - SHIFT_W'(1);

  // remainder step and final correction
  assign mval = mix_q[cmd_i.ord];
  assign mag  = mval[63] ? (64'd0 - mval) : mval;
  assign r2   = {rem_q, dvd_q[63]};
  assign ge   = r2 >= {1'b0, p_q};
  always_comb begin
    if (p_q == '0) res = '0;
    else if (!neg_q) res = rem_q;
    else if (rem_q != '0) res = p_q - rem_q;
    else res = '0;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eos_q       <= '0;
      ord_cfg_q   <= 2'd3;
      heads_cfg_q <= 4'd8;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_EOS) eos_q <= cfg_data_i;
      if (cfg_idx_i == CFG_ORDER) ord_cfg_q <= cfg_data_i[1:0];
      if (cfg_idx_i == CFG_HEADS) heads_cfg_q <= cfg_data_i[3:0];
    end
  end

  // token history and segment count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0;
      for (int k = 0; k < PREV_DEPTH; k++) prev_q[k] <= '0;
    end else if (in_acc_i && in_i.kind == KIND_START) begin
      seg_q <= '0;
    end else if (cmd_i.hist_upd) begin
      prev_q[0] <= tok_q;
      for (int k = 1; k < PREV_DEPTH; k++) prev_q[k] <= prev_q[k-1];
      if (tok_q == eos_t) seg_q <= '0;
      else if ({1'b0, seg_q} < (SEG_W+1)'(PREV_DEPTH)) seg_q <= seg_q + SEG_W'(1);
    end
  end

  // tables
  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      if (in_i.kind == KIND_MUL && {1'b0, in_i.table_index} < 5'(NGRAM_MAX))
        mult_q[in_i.table_index[MUL_IW-1:0]] <= in_i.table_value;
      if (in_i.kind == KIND_MOD)
        mod_q[in_i.table_index[HEAD_IW-1:0]] <= in_i.table_value[31:0];
      if (in_i.kind == KIND_OFF)
        off_q[in_i.table_index[HEAD_IW-1:0]] <= in_i.table_value[40:0];
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.tok_load) tok_q <= in_i.token[TOKEN_BITS-1:0];
    if (cmd_i.mul_en) begin
      unique case (cmd_i.phase)
        2'd0: mul_q <= prod;
        2'd1: begin
          part_q <= mul_q;
          mul_q  <= prod;
        end
        default: begin
          acc_q <= acc_d;
          if (cmd_i.shift != '0) mix_q[sm1[ORD_W-1:0]] <= acc_d;
        end
      endcase
    end
    if (cmd_i.div_init) begin
      dvd_q <= mag;
      neg_q <= mval[63];
      rem_q <= '0;
      p_q   <= mod_q[cmd_i.head];
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= ge ? 32'(r2 - {1'b0, p_q}) : r2[31:0];
    end
    if (cmd_i.fin) begin
      out_q.head     <= cmd_i.head;
      out_q.ngram_id <= {9'd0, res} + off_q[cmd_i.head];
      out_q.last     <= cmd_i.last;
    end
  end

  assign out_o = out_q;

endmodule

FILE: src/eos_aware_ngram_hash_index.sv
// ----------------------------------------------------------------------------
// eos_aware_ngram_hash_index: hashed n-gram index with end-token segments
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage: load the multipliers, moduli and offsets with load items, then send
// tokens. Items are taken one at a time. A load or sequence-start item is
// taken in the idle state. A token first passes through the shared 32x32
// multiplier, forming the mixed products in a low-half, high-half and
// accumulate phase for each shifted token; then each head result takes one
// divisor load, 64 steps of the one-bit-a-cycle remainder unit on the 64-bit
// magnitude, one correction and an output wait until the result is taken.
// No new item is taken until the last head result of a token is delivered.
module eos_aware_ngram_hash_index (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ngh_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ngh_pkg::out_t out_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);
  import ngh_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  ngh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ngh_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for eos_aware_ngram_hash_index
// Fills the tables and then sends directed and random items through a
// queue-fed driver. Both sides idle in random bursts. The receiver holds off
// once for a long stretch. Each item taken is run through a local hash
// predictor, and the monitor checks every head result against the oldest
// expected one.
// ----------------------------------------------------------------------------
module tb_top;
  import ngh_pkg::*;

  localparam int WATCH_LIMIT = 6000;
  localparam int SETTLE      = 1300;
  localparam int HOLD_LEN    = 450;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  in_t           in_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  out_t          out_o;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = 2'd0;
  logic [31:0]   cfg_data_i = '0;

  eos_aware_ngram_hash_index u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // predictor state
  logic [31:0] eos_reg;
  logic [1:0]  order_reg;
  logic [3:0]  heads_reg;
  logic [31:0] hist_tok [PREV_DEPTH];
  int          seg_cnt;
  logic [62:0] mul_tab [NGRAM_MAX];
  logic [31:0] mod_tab [HEAD_DEPTH];
  logic [40:0] off_tab [HEAD_DEPTH];

  in_t  pend_q [$];
  out_t id_q   [$];
  int   err_cnt = 0;

  logic in_taken = 1'b0;
  int   in_gap = 0;
  int   rdy_gap = 0;
  int   hold_cnt = 0;
  bit   hold_req = 0;
  bit   hold_used = 0;
  bit   quiet = 0;
  int   idle_cnt = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // append one item to the driver queue
  task automatic put_item(input in_t it);
    pend_q.insert(pend_q.size(), it);
  endtask

  // floor modulo of a signed 64-bit value by an unsigned modulus, zero for a zero modulus
  function automatic logic [63:0] floor_rem(logic [63:0] m, logic [31:0] p);
    logic [63:0] r;
    if (p == 0) return 64'd0;
    if (!m[63]) return m % 64'(p);
    r = (64'd0 - m) % 64'(p);
    return (r != 0) ? 64'(p) - r : 64'd0;
  endfunction

  // update the local state and queue the head results of one item
  task automatic hash_item(input in_t it);
    logic [31:0] sh [NGRAM_MAX];
    logic [63:0] mixed;
    int          ord, hds, total, cnt, h;
    out_t        r;
    case (it.kind)
      KIND_MUL:   if (it.table_index < NGRAM_MAX) mul_tab[it.table_index] = it.table_value;
      KIND_MOD:   if (it.table_index < HEAD_DEPTH) mod_tab[it.table_index] = it.table_value[31:0];
      KIND_OFF:   if (it.table_index < HEAD_DEPTH) off_tab[it.table_index] = it.table_value[40:0];
      KIND_START: seg_cnt = 0;
      KIND_TOKEN: begin
        ord = (order_reg < 2) ? 2 : ((order_reg > NGRAM_MAX) ? NGRAM_MAX : order_reg);
        hds = (heads_reg > HEADS_MAX) ? HEADS_MAX : heads_reg;
        total = (ord - 1) * hds;
        cnt = 0;
        sh[0] = it.token;
        for (int s = 1; s < NGRAM_MAX; s++) sh[s] = (seg_cnt >= s) ? hist_tok[s-1] : eos_reg;
        for (int n = 2; n <= ord; n++) begin
          mixed = 64'(sh[0]) * 64'(mul_tab[0]);
          for (int s = 1; s < n; s++) mixed ^= 64'(sh[s]) * 64'(mul_tab[s]);
          for (int j = 0; j < hds; j++) begin
            h = (n - 2) * hds + j;
            r.head = 4'(h);
            r.ngram_id = 41'(floor_rem(mixed, mod_tab[h]) + 64'(off_tab[h]));
            cnt++;
            r.last = (cnt == total);
            id_q.insert(id_q.size(), r);
          end
        end
        for (int s = PREV_DEPTH - 1; s > 0; s--) hist_tok[s] = hist_tok[s-1];
        hist_tok[0] = it.token;
        if (it.token == eos_reg) seg_cnt = 0;
        else if (seg_cnt < PREV_DEPTH) seg_cnt++;
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold the item until taken
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 17) - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() != 0) begin
        in_i <= pend_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver ready with bursts and one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_used) begin
        hold_used <= 1;
        hold_cnt <= HOLD_LEN - 1;
        out_ready_i <= 1'b0;
      end else if (rdy_gap > 0) begin
        rdy_gap <= rdy_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rdy_gap <= $urandom_range(1, 17) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor, predictor hook and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) hash_item(in_i);
      if (out_valid_o && out_ready_i) begin
        if (id_q.size() == 0) begin
          report("unexpected result", 64'(out_o), 64'd0);
        end else begin
          if (out_o.head != id_q[0].head) report("head", 64'(out_o.head), 64'(id_q[0].head));
          if (out_o.ngram_id != id_q[0].ngram_id)
            report("ngram_id", 64'(out_o.ngram_id), 64'(id_q[0].ngram_id));
          if (out_o.last != id_q[0].last) report("last", 64'(out_o.last), 64'(id_q[0].last));
          void'(id_q.pop_front());
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
      else if (pend_q.size() != 0 || in_valid_i || id_q.size() != 0) begin
        idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCH_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_EOS:   eos_reg = val;
      CFG_ORDER: order_reg = val[1:0];
      default:   heads_reg = val[3:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || in_valid_i || id_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic in_t mk(input logic [2:0] k, input logic [31:0] tok,
                             input logic [3:0] idx, input logic [62:0] val);
    in_t it;
    it.kind = k;
    it.token = tok;
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic in_t rand_item();
    int          sel;
    logic [31:0] tok;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       tok = $urandom_range(0, 7);
      1:       tok = eos_reg;
      default: tok = $urandom;
    endcase
    if (sel < 70) return mk(KIND_TOKEN, tok, 4'($urandom), rand63());
    if (sel < 80) return mk(KIND_START, $urandom, 4'($urandom), rand63());
    if (sel < 84) return mk(KIND_MUL, $urandom, 4'($urandom), rand63());
    if (sel < 89) return mk(KIND_MOD, $urandom, 4'($urandom),
                            ($urandom_range(0, 5) == 0) ? 63'd0 : rand63());
    if (sel < 94) return mk(KIND_OFF, $urandom, 4'($urandom), rand63());
    return mk(3'($urandom_range(5, 7)), $urandom, 4'($urandom), rand63());
  endfunction

  initial begin
    eos_reg = 32'd0;
    order_reg = 2'd3;
    heads_reg = 4'd8;
    seg_cnt = 0;
    for (int i = 0; i < PREV_DEPTH; i++) hist_tok[i] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // table fill, including the ignored multiplier slots
    put_item(mk(KIND_MUL, 0, 0, {63{1'b1}}));
    put_item(mk(KIND_MUL, 0, 1, rand63()));
    put_item(mk(KIND_MUL, 0, 2, rand63()));
    put_item(mk(KIND_MUL, 0, 3, 63'd0));
    put_item(mk(KIND_MUL, 0, 15, 63'd0));
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      put_item(mk(KIND_MOD, 0, 4'(i),
        (i == 3) ? 63'd0 : (i == 5) ? 63'h7fff_ffff_ffff_ffff : rand63()));
      put_item(mk(KIND_OFF, 0, 4'(i), (i == 7) ? {63{1'b1}} : rand63()));
    end

    // directed: end-token segments, sequence start, unknown kinds
    put_item(mk(KIND_TOKEN, 32'hffff_ffff, 0, 0));
    put_item(mk(KIND_TOKEN, 32'h0, 0, 0));
    put_item(mk(KIND_TOKEN, 32'h1234_5678, 0, 0));
    put_item(mk(KIND_TOKEN, 32'h8000_0001, 0, 0));
    put_item(mk(KIND_TOKEN, 32'hdead_beef, 0, 0));
    put_item(mk(KIND_START, 32'hffff_ffff, 4'hf, {63{1'b1}}));
    put_item(mk(KIND_TOKEN, 32'h7, 0, 0));
    put_item(mk(3'd5, 32'h7, 4'h1, 63'd1));
    put_item(mk(3'd7, 32'h9, 4'h0, 63'd0));
    put_item(mk(KIND_TOKEN, 32'h9, 0, 0));
    drain();

    cfg_write(CFG_EOS, 32'hffff_ffff);
    cfg_write(CFG_ORDER, 32'd0);
    cfg_write(CFG_HEADS, 32'hffff_ffff);
    put_item(mk(KIND_TOKEN, 32'h5, 0, 0));
    put_item(mk(KIND_TOKEN, 32'hffff_ffff, 0, 0));
    put_item(mk(KIND_TOKEN, 32'h6, 0, 0));
    put_item(mk(KIND_TOKEN, 32'h7, 0, 0));
    drain();

    cfg_write(CFG_ORDER, 32'd1);
    cfg_write(CFG_HEADS, 32'd0);
    put_item(mk(KIND_TOKEN, 32'h11, 0, 0));
    put_item(mk(KIND_TOKEN, 32'h12, 0, 0));
    drain();
    cfg_write(CFG_ORDER, 32'd3);
    cfg_write(CFG_HEADS, 32'd1);
    put_item(mk(KIND_TOKEN, 32'h13, 0, 0));
    put_item(mk(KIND_TOKEN, 32'h14, 0, 0));
    drain();

    // random phases; mostly few heads to keep each token short
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_EOS, ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 7)) : $urandom);
      cfg_write(CFG_ORDER, 32'($urandom_range(0, 3)));
      cfg_write(CFG_HEADS,
                (ph == 2) ? 32'($urandom_range(4, 15)) : 32'($urandom_range(1, 3)));
      if (ph == 5) quiet = 1;
      for (int i = 0; i < 36; i++) put_item(rand_item());
      if (ph == 3) begin
        repeat (20) @(posedge clk_i);
        hold_req = 1;
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
